### sv/m4rm_pkg.sv
package m4rm_pkg;

  // element format
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = 2;
  localparam int DIM       = 4;

  // truncated product drops the low FRAC_BITS bits of the full double-width product
  localparam int FULL_W = 2 * ELEM_W;
  localparam int PROD_W = FULL_W - FRAC_BITS;
  // four products summed exactly
  localparam int SUM_W  = PROD_W + 2;

  // opcodes
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_MUL  = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef elem_t [DIM-1:0]          row_t;
  typedef elem_t [DIM-1:0][DIM-1:0] mat_t;   // [row][col]
  typedef prod_t [DIM-1:0][DIM-1:0] prod_blk_t; // [col][k]

  typedef struct packed {
    logic             opcode;
    logic [ROW_W-1:0] row_index;
    elem_t            elem0;
    elem_t            elem1;
    elem_t            elem2;
    elem_t            elem3;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    elem_t            out_elem0;
    elem_t            out_elem1;
    elem_t            out_elem2;
    elem_t            out_elem3;
  } out_item_t;

  // products in flight between the multiply and sum stages
  typedef struct packed {
    logic [ROW_W-1:0] row;
    prod_blk_t        prod;
  } prod_item_t;

endpackage

### sv/m4rm_store.sv
module m4rm_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [m4rm_pkg::ROW_W-1:0] wr_row,
  input  m4rm_pkg::row_t            wr_data,
  output m4rm_pkg::mat_t            mat
);
  import m4rm_pkg::*;

  mat_t mat_r;

  // right matrix rows, cleared to zero on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (wr_en) begin
      mat_r[wr_row] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

### sv/m4rm_mult.sv
module m4rm_mult (
  input  logic                       clk,
  input  logic                       en,
  input  logic [m4rm_pkg::ROW_W-1:0] row,
  input  m4rm_pkg::row_t             a_row,
  input  m4rm_pkg::mat_t             mat,
  output m4rm_pkg::prod_item_t       prod_item
);
  import m4rm_pkg::*;

  prod_item_t prod_r;
  prod_item_t prod_nxt;

  // sixteen independent products, floor-truncated by dropping fraction bits
  always_comb begin
    logic signed [FULL_W-1:0] full;
    prod_nxt.row = row;
    prod_nxt.prod = '0;
    for (int j = 0; j < DIM; j++) begin
      for (int k = 0; k < DIM; k++) begin
        full = $signed(a_row[k]) * $signed(mat[k][j]);
        prod_nxt.prod[j][k] = full[FULL_W-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_item = prod_r;

endmodule

### sv/m4rm_acc.sv
module m4rm_acc (
  input  logic                 clk,
  input  logic                 en,
  input  m4rm_pkg::prod_item_t prod_item,
  output m4rm_pkg::out_item_t  out_item
);
  import m4rm_pkg::*;

  out_item_t out_r;
  out_item_t out_nxt;
  row_t      sat;

  // exact sum of four products, then saturate to the element range
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    sat = '0;
    for (int j = 0; j < DIM; j++) begin
      sum = '0;
      for (int k = 0; k < DIM; k++) begin
        sum = sum + SUM_W'($signed(prod_item.prod[j][k]));
      end
      if ((&sum[SUM_W-1:ELEM_W-1]) || !(|sum[SUM_W-1:ELEM_W-1])) begin
        sat[j] = sum[ELEM_W-1:0];
      end else if (sum[SUM_W-1]) begin
        sat[j] = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        sat[j] = {1'b0, {(ELEM_W-1){1'b1}}};
      end
    end
    out_nxt.out_row   = prod_item.row;
    out_nxt.out_elem0 = sat[0];
    out_nxt.out_elem1 = sat[1];
    out_nxt.out_elem2 = sat[2];
    out_nxt.out_elem3 = sat[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

### sv/matrix4_row_multiply.sv
// a multiply item moves from the input register to the product register, then to the result register
// throughput: one item per cycle while the output is not stalled, loads and multiplies mixed freely
// a load item writes one row of the right matrix and gives no result
// rate is set by the registers at input, after the 16 multipliers and at output
// reset (synchronous, active low) clears the right matrix to zero and empties the pipe
module matrix4_row_multiply (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m4rm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output m4rm_pkg::out_item_t out_data
);
  import m4rm_pkg::*;

  in_item_t   in_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s2_valid_r, s2_valid_nxt;
  logic       s3_valid_r, s3_valid_nxt;
  logic       in_take;
  logic       s1_is_mul, s1_go;
  logic       s2_free, s2_go;
  logic       s3_free;
  row_t       s1_row;
  mat_t       mat;
  prod_item_t prod_item;

  // pipe advance control
  assign s3_free   = !s3_valid_r || !out_stall;
  assign s2_go     = s2_valid_r && s3_free;
  assign s2_free   = !s2_valid_r || s3_free;
  assign s1_is_mul = (in_r.opcode == OPC_MUL);
  assign s1_go     = s1_valid_r && (!s1_is_mul || s2_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;

  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
  assign s2_valid_nxt = (s1_go && s1_is_mul) || (s2_valid_r && !s2_go);
  assign s3_valid_nxt = s2_go || (s3_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  assign s1_row = {in_r.elem3, in_r.elem2, in_r.elem1, in_r.elem0};

  // loads write as they leave the input stage, so later multiplies see them in order
  m4rm_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_go && !s1_is_mul),
    .wr_row  (in_r.row_index),
    .wr_data (s1_row),
    .mat     (mat)
  );

  m4rm_mult u_mult (
    .clk       (clk),
    .en        (s1_go && s1_is_mul),
    .row       (in_r.row_index),
    .a_row     (s1_row),
    .mat       (mat),
    .prod_item (prod_item)
  );

  m4rm_acc u_acc (
    .clk       (clk),
    .en        (s2_go),
    .prod_item (prod_item),
    .out_item  (out_data)
  );

  assign out_valid = s3_valid_r;

  // a load leaving the input stage never fills the product stage
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_is_mul && s2_free) |=> !s2_valid_r)
    else $error("load item reached product stage");

  // a multiply leaving the input stage lands in the product stage
  a_mul_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_mul && s2_free) |=> s2_valid_r)
    else $error("multiply item lost");

  // products held while the result register is blocked
  a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_free) |=> (s2_valid_r && $stable(prod_item)))
    else $error("product stage overwritten while blocked");

endmodule
